// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the classifier RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication assertion failed");

// Next-cycle implication, disabled while reset is held
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle assertion failed");

`endif

// ===== rtl/core/jmsc_pkg.sv =====
// Shared types, constants and the marker classifier function.
// Depends on nothing; imported by every module of the classifier.
package jmsc_pkg;

    localparam int unsigned ByteW = 8;
    localparam int unsigned WordW = 16;

    localparam logic [WordW-1:0] SOI_WORD = 16'hFFD8;
    localparam logic [WordW-1:0] LEN_BIAS = 16'd2;

    // Parse position within the buffer
    typedef enum logic [2:0] {
        PH_SOI_HI = 3'd0,
        PH_SOI_LO = 3'd1,
        PH_MRK_HI = 3'd2,
        PH_MRK_LO = 3'd3,
        PH_LEN_HI = 3'd4,
        PH_LEN_LO = 3'd5,
        PH_SKIP   = 3'd6
    } phase_t;

    typedef enum logic [1:0] {
        CLS_OTHER = 2'd0,
        CLS_LOSSY = 2'd1,
        CLS_STOP  = 2'd2
    } marker_cls_t;

    // Outcome of one byte step
    typedef struct packed {
        logic decided;
        logic verdict;
    } scan_res_t;

    function automatic marker_cls_t classify(input logic [WordW-1:0] word);
        marker_cls_t cls;
        case (word) inside
            16'hFFC0, 16'hFFC1, 16'hFFC2, 16'hFFC5, 16'hFFC6,
            16'hFFC9, 16'hFFCA, 16'hFFCD, 16'hFFCE: cls = CLS_LOSSY;
            16'hFFC3, 16'hFFC7, 16'hFFCB, 16'hFFCF, 16'hFFDA: cls = CLS_STOP;
            default: cls = CLS_OTHER;
        endcase
        return cls;
    endfunction

endpackage

// ===== rtl/core/jmsc_scan.sv =====
// Marker parser state machine: one byte step per transaction.
// Depends on jmsc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module jmsc_scan (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        step,
    input  logic [jmsc_pkg::ByteW-1:0]  data_byte,
    input  logic                        last_byte,
    output jmsc_pkg::scan_res_t         res
);
    import jmsc_pkg::*;

    phase_t           phase_reg, phase_next;
    logic [ByteW-1:0] pending_reg, pending_next;
    logic [WordW-1:0] skip_reg, skip_next;
    logic             given_reg, given_next;

    logic [WordW-1:0] word;
    logic [WordW-1:0] skip_len;
    logic [WordW-1:0] skip_dec;
    marker_cls_t      cls;

    assign word     = {pending_reg, data_byte};
    assign skip_len = word - LEN_BIAS;
    assign skip_dec = skip_reg - 16'd1;
    assign cls      = classify(word);

    // Hold the phase, skip count and verdict flag; the high byte store needs no reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_SOI_HI;
            skip_reg  <= '0;
            given_reg <= 1'b0;
        end else if (step) begin
            phase_reg <= phase_next;
            skip_reg  <= skip_next;
            given_reg <= given_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            pending_reg <= pending_next;
        end
    end

    // Advance the parse by one byte
    always_comb begin
        phase_next   = phase_reg;
        pending_next = pending_reg;
        skip_next    = skip_reg;
        given_next   = given_reg;
        res.decided  = 1'b0;
        res.verdict  = 1'b0;

        if (!given_reg) begin
            case (phase_reg)
                PH_SOI_LO: begin
                    if (word != SOI_WORD) begin
                        res.decided = 1'b1;
                    end else begin
                        phase_next = PH_MRK_HI;
                    end
                end
                PH_MRK_HI: begin
                    pending_next = data_byte;
                    phase_next   = PH_MRK_LO;
                end
                PH_MRK_LO: begin
                    if (cls == CLS_LOSSY) begin
                        res.decided = 1'b1;
                        res.verdict = 1'b1;
                    end else if (cls == CLS_STOP) begin
                        res.decided = 1'b1;
                    end else begin
                        phase_next = PH_LEN_HI;
                    end
                end
                PH_LEN_HI: begin
                    pending_next = data_byte;
                    phase_next   = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    skip_next  = skip_len;
                    phase_next = (skip_len == '0) ? PH_MRK_HI : PH_SKIP;
                end
                PH_SKIP: begin
                    skip_next = skip_dec;
                    if (skip_dec == '0) begin
                        phase_next = PH_MRK_HI;
                    end
                end
                default: begin
                    pending_next = data_byte;
                    phase_next   = PH_SOI_LO;
                end
            endcase

            // Close an undecided buffer on its last byte
            if (!res.decided && last_byte) begin
                res.decided = 1'b1;
                res.verdict = 1'b0;
            end
        end

        // Rearm for the next buffer, or latch that a verdict went out
        if (last_byte) begin
            phase_next = PH_SOI_HI;
            skip_next  = '0;
            given_next = 1'b0;
        end else if (res.decided) begin
            given_next = 1'b1;
        end
    end

    `ASSERT_NEXT(a_last_rearms, aclk, aresetn, step && last_byte,
        phase_reg == PH_SOI_HI && !given_reg && skip_reg == '0)
    `ASSERT_NEXT(a_verdict_latched, aclk, aresetn, step && res.decided && !last_byte,
        given_reg)
    `ASSERT_IMPLY(a_skip_nonzero, aclk, aresetn, phase_reg == PH_SKIP, skip_reg != '0)

endmodule

// ===== rtl/core/jmsc_out_buf.sv =====
// Result register with a skid entry, decoupling the parser from m_tready.
// Depends on jmsc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module jmsc_out_buf (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 step,
    input  jmsc_pkg::scan_res_t  res,
    output logic                 ready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic                 m_verdict
);
    import jmsc_pkg::*;

    logic main_valid_reg, skid_valid_reg;
    logic main_data_reg, skid_data_reg;
    logic push, pop;

    assign push      = step && res.decided;
    assign pop       = main_valid_reg && m_tready;
    assign ready     = !skid_valid_reg;
    assign m_tvalid  = main_valid_reg;
    assign m_verdict = main_data_reg;

    // Fill main first, spill to skid when main is stalled, refill main from skid on a pop
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (pop) begin
                main_valid_reg <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end else if (push) begin
            if (main_valid_reg && !pop) begin
                skid_valid_reg <= 1'b1;
            end else begin
                main_valid_reg <= 1'b1;
            end
        end else if (pop) begin
            main_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (pop) begin
                main_data_reg <= skid_data_reg;
            end
        end else if (push) begin
            if (main_valid_reg && !pop) begin
                skid_data_reg <= res.verdict;
            end else begin
                main_data_reg <= res.verdict;
            end
        end
    end

    `ASSERT_IMPLY(a_skid_behind_main, aclk, aresetn, skid_valid_reg, main_valid_reg)
    `ASSERT_IMPLY(a_no_push_when_full, aclk, aresetn, push, !skid_valid_reg)
    `ASSERT_NEXT(a_skid_holds, aclk, aresetn, skid_valid_reg && !m_tready,
        skid_valid_reg && $stable(skid_data_reg))

endmodule

// ===== rtl/core/jpeg_marker_scan_classifier.sv =====
// A deciding byte sits in the input register; its verdict is registered in the result stage.
// Throughput: one byte per cycle while s_tready is high; phase and skip counter step per byte.
// Input register, parser and result register with skid; s_tready drops only while
// two verdicts wait on m_tready.
// Reset: synchronous active-low aresetn clears the parser to await a new buffer and empties
// both the input stage and the result stage.
module jpeg_marker_scan_classifier (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic       s_tlast,   // last_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // [0] is_jpeg, [7:1] zero
);
    import jmsc_pkg::*;

    logic             in_valid_reg;
    logic [ByteW-1:0] in_byte_reg;
    logic             in_last_reg;
    logic             consume;
    logic             buf_ready;
    logic             verdict;
    scan_res_t        res;

    assign consume  = in_valid_reg && buf_ready;
    assign s_tready = !in_valid_reg || consume;
    assign m_tdata  = {7'd0, verdict};

    // Input register: take a new transaction when empty or whenever the held one moves on
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    jmsc_scan u_scan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (consume),
        .data_byte (in_byte_reg),
        .last_byte (in_last_reg),
        .res       (res)
    );

    jmsc_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (consume),
        .res       (res),
        .ready     (buf_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_verdict (verdict)
    );

endmodule

// ===== tb/sv/jpeg_marker_scan_classifier_tb.sv =====
// Self-checking testbench for the JPEG marker scan classifier.
// Depends on jmsc_pkg for phase and marker class types, and on the classifier RTL.
module jpeg_marker_scan_classifier_tb;
    import jmsc_pkg::*;

    // Marker prefix and marker codes used by the scan
    localparam logic [7:0] MRK_PFX = 8'hFF;
    localparam logic [7:0] SOI_LO  = 8'hD8;
    localparam logic [7:0] SOF0    = 8'hC0;
    localparam logic [7:0] SOF1    = 8'hC1;
    localparam logic [7:0] SOF2    = 8'hC2;
    localparam logic [7:0] SOF3    = 8'hC3;
    localparam logic [7:0] SOF5    = 8'hC5;
    localparam logic [7:0] SOF6    = 8'hC6;
    localparam logic [7:0] SOF7    = 8'hC7;
    localparam logic [7:0] SOF9    = 8'hC9;
    localparam logic [7:0] SOF10   = 8'hCA;
    localparam logic [7:0] SOF11   = 8'hCB;
    localparam logic [7:0] SOF13   = 8'hCD;
    localparam logic [7:0] SOF14   = 8'hCE;
    localparam logic [7:0] SOF15   = 8'hCF;
    localparam logic [7:0] SOS     = 8'hDA;
    localparam logic [7:0] APP0    = 8'hE0;
    localparam logic [7:0] APP1    = 8'hE1;
    localparam logic [7:0] COM     = 8'hFE;

    localparam logic [7:0] LOSSY_CODES [9] = '{SOF0, SOF1, SOF2, SOF5, SOF6,
                                               SOF9, SOF10, SOF13, SOF14};
    localparam logic [7:0] STOP_CODES  [5] = '{SOF3, SOF7, SOF11, SOF15, SOS};

    localparam int RAND_ITEMS  = 500;
    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_CYCLES = 8;

    // How the expected verdict of a table row is obtained
    typedef enum logic [1:0] {
        EXP_MODEL = 2'd0,
        EXP_NONE  = 2'd1,
        EXP_ZERO  = 2'd2,
        EXP_ONE   = 2'd3
    } exp_kind_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        exp_kind_t  kind;
    } dir_row_t;

    localparam int DIR_ROWS = 24;
    localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
        // buffer ending mid-word straight after reset
        '{8'h00, 1'b1, EXP_ZERO},
        // wrong start word, then a byte that is ignored
        '{MRK_PFX, 1'b0, EXP_NONE},
        '{8'h00,   1'b0, EXP_ZERO},
        '{8'hAB,   1'b1, EXP_NONE},
        // lossy frame start decided on the last byte
        '{MRK_PFX, 1'b0, EXP_NONE},
        '{SOI_LO,  1'b0, EXP_NONE},
        '{MRK_PFX, 1'b0, EXP_NONE},
        '{SOF0,    1'b1, EXP_ONE},
        // one segment with a one-byte skip, then a lossless frame start
        '{MRK_PFX, 1'b0, EXP_MODEL},
        '{SOI_LO,  1'b0, EXP_MODEL},
        '{MRK_PFX, 1'b0, EXP_MODEL},
        '{APP1,    1'b0, EXP_MODEL},
        '{8'h00,   1'b0, EXP_MODEL},
        '{8'h03,   1'b0, EXP_MODEL},
        '{8'h7F,   1'b0, EXP_MODEL},
        '{MRK_PFX, 1'b0, EXP_MODEL},
        '{SOF3,    1'b1, EXP_ZERO},
        // zero length wraps; buffer ends right after the length word
        '{MRK_PFX, 1'b0, EXP_MODEL},
        '{SOI_LO,  1'b0, EXP_MODEL},
        '{MRK_PFX, 1'b0, EXP_MODEL},
        '{COM,     1'b0, EXP_MODEL},
        '{8'h00,   1'b0, EXP_MODEL},
        '{8'h00,   1'b1, EXP_ZERO},
        // single all-ones byte as a whole buffer
        '{MRK_PFX, 1'b1, EXP_ZERO}
    };

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;   // [7:0] data_byte
    logic       s_tlast  = 1'b0;    // last_byte
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;            // [0] is_jpeg, [7:1] zero

    // Predictor state
    phase_t      pr_phase = PH_SOI_HI;
    logic [7:0]  pr_hi    = 8'h00;
    logic [15:0] pr_skip  = 16'h0000;
    bit          pr_done  = 1'b0;

    logic        verdict_q [$];
    logic [7:0]  byte_q [$];
    int          err_cnt      = 0;
    int          cycle_cnt    = 0;
    int          live_cnt     = 0;
    int          src_idle_pct = 33;
    int          snk_stall_pct = 57;

    jpeg_marker_scan_classifier u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
    end

    // Stall the result channel at random
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= snk_stall_pct);
    end

    task automatic report_mismatch(input string what, input logic [7:0] exp_v,
                                   input logic [7:0] got_v);
        $display("mismatch at cycle %0d: %s expected %02h got %02h",
                 cycle_cnt, what, exp_v, got_v);
        err_cnt++;
    endtask

    function automatic marker_cls_t marker_kind(input logic [15:0] word);
        marker_cls_t k;
        k = CLS_OTHER;
        if (word[15:8] == MRK_PFX) begin
            case (word[7:0])
                SOF0, SOF1, SOF2, SOF5, SOF6, SOF9, SOF10, SOF13, SOF14: k = CLS_LOSSY;
                SOF3, SOF7, SOF11, SOF15, SOS: k = CLS_STOP;
                default: k = CLS_OTHER;
            endcase
        end
        return k;
    endfunction

    // Advance the predicted parser by one byte; report any verdict it gives
    task automatic predict_verdict(input logic [7:0] b, input logic lst,
                                   output bit found, output logic v);
        logic [15:0] word;
        found = 1'b0;
        v     = 1'b0;
        word  = {pr_hi, b};
        if (!pr_done) begin
            case (pr_phase)
                PH_SOI_LO: begin
                    if (word != SOI_WORD) found = 1'b1;
                    else pr_phase = PH_MRK_HI;
                end
                PH_MRK_HI: begin
                    pr_hi    = b;
                    pr_phase = PH_MRK_LO;
                end
                PH_MRK_LO: begin
                    case (marker_kind(word))
                        CLS_LOSSY: begin
                            found = 1'b1;
                            v     = 1'b1;
                        end
                        CLS_STOP: found = 1'b1;
                        default: pr_phase = PH_LEN_HI;
                    endcase
                end
                PH_LEN_HI: begin
                    pr_hi    = b;
                    pr_phase = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    pr_skip = word - LEN_BIAS;
                    if (pr_skip == 16'h0000) pr_phase = PH_MRK_HI;
                    else pr_phase = PH_SKIP;
                end
                PH_SKIP: begin
                    pr_skip = pr_skip - 16'd1;
                    if (pr_skip == 16'h0000) pr_phase = PH_MRK_HI;
                end
                default: begin
                    pr_hi    = b;
                    pr_phase = PH_SOI_LO;
                end
            endcase
            if (!found && lst) found = 1'b1;
        end
        // Return to the start of a buffer after its last byte
        if (lst) begin
            pr_phase = PH_SOI_HI;
            pr_hi    = 8'h00;
            pr_skip  = 16'h0000;
            pr_done  = 1'b0;
        end else if (found) begin
            pr_done = 1'b1;
        end
    endtask

    // Offer one byte, hold it until taken, then queue its expected verdict
    task automatic send_byte(input logic [7:0] b, input logic lst, input exp_kind_t kind);
        bit   found;
        logic v;
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= lst;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (!pr_done) live_cnt++;
        predict_verdict(b, lst, found, v);
        case (kind)
            EXP_MODEL: if (found) verdict_q.push_back(v);
            EXP_ZERO:  verdict_q.push_back(1'b0);
            EXP_ONE:   verdict_q.push_back(1'b1);
            default: ;
        endcase
    endtask

    task automatic send_buffer();
        foreach (byte_q[i]) send_byte(byte_q[i], i == byte_q.size() - 1, EXP_MODEL);
    endtask

    // Build a buffer: mostly well-formed marker streams, some noise and truncation
    task automatic gen_buffer();
        int          n;
        int          nseg;
        int          pick;
        int          cut;
        logic [15:0] word;
        logic [15:0] len;
        byte_q.delete();
        pick = $urandom_range(99);
        if (pick < 10) begin
            n = $urandom_range(1, 6);
            repeat (n) byte_q.push_back(8'($urandom));
            return;
        end
        // start word, now and then a wrong one
        if ($urandom_range(9) == 0) begin
            word = 16'($urandom);
            byte_q.push_back(word[15:8]);
            byte_q.push_back(word[7:0]);
        end else begin
            byte_q.push_back(MRK_PFX);
            byte_q.push_back(SOI_LO);
        end
        nseg = $urandom_range(0, 3);
        repeat (nseg) begin
            do begin
                word = {MRK_PFX, 8'($urandom)};
                if ($urandom_range(7) == 0) word[15:8] = 8'($urandom);
            end while (marker_kind(word) != CLS_OTHER);
            if ($urandom_range(9) == 0) len = 16'd2;
            else len = 16'($urandom_range(2, 7));
            byte_q.push_back(word[15:8]);
            byte_q.push_back(word[7:0]);
            byte_q.push_back(len[15:8]);
            byte_q.push_back(len[7:0]);
            repeat (int'(len) - 2) byte_q.push_back(8'($urandom));
        end
        // closing marker: lossy, stopping, or none
        pick = $urandom_range(99);
        if (pick < 45) begin
            byte_q.push_back(MRK_PFX);
            byte_q.push_back(LOSSY_CODES[$urandom_range(8)]);
        end else if (pick < 75) begin
            byte_q.push_back(MRK_PFX);
            byte_q.push_back(STOP_CODES[$urandom_range(4)]);
        end
        n = $urandom_range(0, 3);
        repeat (n) byte_q.push_back(8'($urandom));
        if ($urandom_range(4) == 0) begin
            cut = $urandom_range(1, byte_q.size());
            while (byte_q.size() > cut) void'(byte_q.pop_back());
        end
    endtask

    // Check each result transaction against the oldest expected verdict
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (verdict_q.size() == 0) begin
                report_mismatch("unexpected verdict", 8'h00, m_tdata);
            end else begin
                if (m_tdata[0] !== verdict_q[0])
                    report_mismatch("is_jpeg", {7'd0, verdict_q[0]}, m_tdata);
                if (m_tdata[7:1] !== 7'd0)
                    report_mismatch("padding", {7'd0, verdict_q[0]}, m_tdata);
                void'(verdict_q.pop_front());
            end
        end
    end

    // Abort on timeout
    initial begin
        while (cycle_cnt < CYCLE_LIMIT) @(posedge aclk);
        $display("FAIL");
        $finish;
    end

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed table
        for (int i = 0; i < DIR_ROWS; i++)
            send_byte(DIR_TAB[i].data, DIR_TAB[i].last, DIR_TAB[i].kind);

        // Random buffers over three idling regimes
        live_cnt = 0;
        while (live_cnt < RAND_ITEMS) begin
            if (live_cnt < RAND_ITEMS / 3) begin
                src_idle_pct  = 33;
                snk_stall_pct = 57;
            end else if (live_cnt < 2 * RAND_ITEMS / 3) begin
                src_idle_pct  = 57;
                snk_stall_pct = 33;
            end else begin
                src_idle_pct  = 0;
                snk_stall_pct = 0;
            end
            gen_buffer();
            send_buffer();
        end

        // Length of one wraps to a 65535-byte skip; the buffer ends inside it
        byte_q.delete();
        byte_q.push_back(MRK_PFX);
        byte_q.push_back(SOI_LO);
        byte_q.push_back(MRK_PFX);
        byte_q.push_back(APP0);
        byte_q.push_back(8'h00);
        byte_q.push_back(8'h01);
        repeat (4) byte_q.push_back(8'($urandom));
        byte_q.push_back(MRK_PFX);
        byte_q.push_back(SOF2);
        send_buffer();
        s_tvalid <= 1'b0;

        // Drain outstanding verdicts
        while (verdict_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (err_cnt == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
